FILE: rtl/pti_pkg.sv
`default_nettype none
package pti_pkg;

    localparam int RAM_DEPTH = 64;
    localparam int ADDR_W    = 6;
    localparam int LANES     = 5;
    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic [31:0] color_finish;
        logic [31:0] color_begin;
        logic [15:0] lifetime_frames;
        logic [15:0] scale_finish;
        logic [15:0] scale_begin;
        logic [47:0] acceleration;
        logic [47:0] start_velocity;
        logic [47:0] start_position;
        logic        action;
    } t_in;

    typedef struct packed {
        logic        last_of_frame;
        logic [31:0] out_color;
        logic [15:0] out_scale;
        logic [47:0] out_position;
    } t_out;

    typedef struct packed {
        logic [15:0] life;
        logic [15:0] frame;
        logic [31:0] color_finish;
        logic [31:0] color_begin;
        logic [15:0] scale_finish;
        logic [15:0] scale_begin;
        logic [47:0] acc;
        logic [47:0] vel;
        logic [47:0] pos;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_WRITE,
        ST_FINISH
    } t_state;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {a[15], a} + {b[15], b};
        if (s[16] != s[15]) begin
            sat_add16 = s[16] ? 16'h8000 : 16'h7fff;
        end else begin
            sat_add16 = s[15:0];
        end
    endfunction

    function automatic logic [47:0] sat_add3(input logic [47:0] a, input logic [47:0] b);
        sat_add3 = {sat_add16(a[47:32], b[47:32]), sat_add16(a[31:16], b[31:16]),
                    sat_add16(a[15:0], b[15:0])};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pti_ram.sv
`default_nettype none
module pti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/particle_table_integrator_core.sv
`default_nettype none
// An add is stored unless the table is full; busy stays low, ready for the next transfer.
// A tick holds busy while it walks the table, dropping expired particles and closing at the end:
// a survivor reads its entry, runs a 32-step shift-subtract divide for the scale and the four
// color channels at once, then writes back. Each result is presented in the cycle after the
// next survivor's write-back, or after the closing state for the last; no stall is possible.
// Synchronous active-low reset empties the table; its contents stay as they were.
module particle_table_integrator_core #(
    parameter int MAX_PARTICLES = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pti_pkg::t_in  i_item,
    output logic               o_valid,
    output pti_pkg::t_out      o_result
);

    localparam int CNT_W = $clog2(pti_pkg::RAM_DEPTH + 1);

    pti_pkg::t_state r_state, n_state;
    logic [pti_pkg::ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count, r_idx, n_idx, r_kept, n_kept;
    logic [4:0] r_step, n_step;
    logic r_pend, n_pend;
    pti_pkg::t_out r_pend_res, n_pend_res, r_out, n_out;
    logic r_out_vld, n_out_vld;
    pti_pkg::t_entry r_ent, n_ent, ram_rd, ram_wd, add_ent;
    logic ram_we;
    logic [pti_pkg::ADDR_W-1:0] ram_wa, ram_ra;
    logic [15:0] r_fr1, n_fr1;
    logic [31:0] r_dvd [pti_pkg::LANES];
    logic [31:0] n_dvd [pti_pkg::LANES];
    logic [16:0] r_rem [pti_pkg::LANES];
    logic [16:0] n_rem [pti_pkg::LANES];
    logic r_neg [pti_pkg::LANES];
    logic n_neg [pti_pkg::LANES];

    logic [15:0] lane_b [pti_pkg::LANES];
    logic [15:0] lane_f [pti_pkg::LANES];
    logic [15:0] ent_b  [pti_pkg::LANES];
    logic [15:0] res_l  [pti_pkg::LANES];
    logic [47:0] new_vel, new_pos;

    pti_ram #(.WIDTH(pti_pkg::ENTRY_W), .DEPTH(pti_pkg::RAM_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(ram_ra),
        .o_rdata(ram_rd)
    );

    assign busy     = (r_state != pti_pkg::ST_IDLE);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    always_comb begin
        add_ent              = '0;
        add_ent.pos          = i_item.start_position;
        add_ent.vel          = i_item.start_velocity;
        add_ent.acc          = i_item.acceleration;
        add_ent.scale_begin  = i_item.scale_begin;
        add_ent.scale_finish = i_item.scale_finish;
        add_ent.color_begin  = i_item.color_begin;
        add_ent.color_finish = i_item.color_finish;
        add_ent.life         = i_item.lifetime_frames;
        add_ent.frame        = 16'd0;
    end

    // Lane 0 is the scale, lanes 1 to 4 the color channels R, G, B, A.
    always_comb begin
        lane_b[0] = ram_rd.scale_begin;
        lane_f[0] = ram_rd.scale_finish;
        ent_b[0]  = r_ent.scale_begin;
        for (int l = 1; l < pti_pkg::LANES; l++) begin
            lane_b[l] = {8'd0, ram_rd.color_begin[(l-1)*8 +: 8]};
            lane_f[l] = {8'd0, ram_rd.color_finish[(l-1)*8 +: 8]};
            ent_b[l]  = {8'd0, r_ent.color_begin[(l-1)*8 +: 8]};
        end
        for (int l = 0; l < pti_pkg::LANES; l++) begin
            res_l[l] = r_neg[l] ? (ent_b[l] - r_dvd[l][15:0]) : (ent_b[l] + r_dvd[l][15:0]);
        end
        new_vel = pti_pkg::sat_add3(r_ent.vel, r_ent.acc);
        new_pos = pti_pkg::sat_add3(r_ent.pos, new_vel);
    end

    always_comb begin
        logic [16:0] rr;
        logic [15:0] mag;
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_kept     = r_kept;
        n_step     = r_step;
        n_pend     = r_pend;
        n_pend_res = r_pend_res;
        n_out      = r_out;
        n_out_vld  = 1'b0;
        n_ent      = r_ent;
        n_fr1      = r_fr1;
        n_dvd      = r_dvd;
        n_rem      = r_rem;
        n_neg      = r_neg;
        ram_we     = 1'b0;
        ram_wa     = r_head + r_kept[pti_pkg::ADDR_W-1:0];
        ram_wd     = r_ent;
        ram_ra     = r_head + r_idx[pti_pkg::ADDR_W-1:0];
        rr         = '0;
        mag        = '0;

        unique case (r_state)
            pti_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_item.action == pti_pkg::ACT_ADD) begin
                        if (r_count < CNT_W'(MAX_PARTICLES)) begin
                            ram_we  = 1'b1;
                            ram_wa  = r_head - 1'b1;
                            ram_wd  = add_ent;
                            n_head  = r_head - 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_idx  = '0;
                        n_kept = '0;
                        n_pend = 1'b0;
                        if (r_count != '0) begin
                            n_state = pti_pkg::ST_READ;
                        end
                    end
                end
            end
            pti_pkg::ST_READ: begin
                n_state = pti_pkg::ST_LOAD;
            end
            pti_pkg::ST_LOAD: begin
                n_ent = ram_rd;
                if (ram_rd.frame >= ram_rd.life) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = (r_idx + 1'b1 == r_count) ? pti_pkg::ST_FINISH
                                                        : pti_pkg::ST_READ;
                end else begin
                    n_fr1 = ram_rd.frame + 1'b1;
                    for (int l = 0; l < pti_pkg::LANES; l++) begin
                        n_neg[l] = (lane_f[l] < lane_b[l]);
                        mag      = n_neg[l] ? (lane_b[l] - lane_f[l]) : (lane_f[l] - lane_b[l]);
                        n_dvd[l] = mag * n_fr1;
                        n_rem[l] = '0;
                    end
                    n_step  = '0;
                    n_state = pti_pkg::ST_DIV;
                end
            end
            pti_pkg::ST_DIV: begin
                for (int l = 0; l < pti_pkg::LANES; l++) begin
                    rr = {r_rem[l][15:0], r_dvd[l][31]};
                    if (rr >= {1'b0, r_ent.life}) begin
                        n_rem[l] = rr - {1'b0, r_ent.life};
                        n_dvd[l] = {r_dvd[l][30:0], 1'b1};
                    end else begin
                        n_rem[l] = rr;
                        n_dvd[l] = {r_dvd[l][30:0], 1'b0};
                    end
                end
                n_step = r_step + 1'b1;
                if (r_step == 5'(pti_pkg::DIV_STEPS - 1)) begin
                    n_state = pti_pkg::ST_WRITE;
                end
            end
            pti_pkg::ST_WRITE: begin
                ram_we       = 1'b1;
                ram_wd       = r_ent;
                ram_wd.vel   = new_vel;
                ram_wd.pos   = new_pos;
                ram_wd.frame = r_fr1;
                n_kept       = r_kept + 1'b1;
                // The previous survivor is now known not to be the last one.
                if (r_pend) begin
                    n_out     = r_pend_res;
                    n_out_vld = 1'b1;
                end
                n_pend                   = 1'b1;
                n_pend_res.out_position  = new_pos;
                n_pend_res.out_scale     = res_l[0];
                n_pend_res.out_color     = {res_l[4][7:0], res_l[3][7:0], res_l[2][7:0],
                                            res_l[1][7:0]};
                n_pend_res.last_of_frame = 1'b0;
                n_idx   = r_idx + 1'b1;
                n_state = (r_idx + 1'b1 == r_count) ? pti_pkg::ST_FINISH : pti_pkg::ST_READ;
            end
            pti_pkg::ST_FINISH: begin
                if (r_pend) begin
                    n_out               = r_pend_res;
                    n_out.last_of_frame = 1'b1;
                    n_out_vld           = 1'b1;
                end
                n_pend  = 1'b0;
                n_count = r_kept;
                n_state = pti_pkg::ST_IDLE;
            end
            default: begin
                n_state = pti_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pti_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_kept    <= '0;
            r_step    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_kept    <= n_kept;
            r_step    <= n_step;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_res <= n_pend_res;
        r_out      <= n_out;
        r_ent      <= n_ent;
        r_fr1      <= n_fr1;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_neg      <= n_neg;
    end

endmodule
`default_nettype wire
